/* hdl/mfhp_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI file header parser package
// Shared types, phase codes, result kinds and error codes.
// ----------------------------------------------------------------------------
package mfhp_pkg;

	localparam int BYTE_W   = 8;
	localparam int POS_W    = 5;
	localparam int FIELD_W  = 32;
	localparam int DIV_W    = 16;
	localparam int FMT_W    = 2;
	localparam int DELTA_W  = 56;
	localparam int DCOUNT_W = 4;

	localparam logic [FIELD_W-1:0]  MAGIC_HEAD      = 32'h4D54_6864;
	localparam logic [FIELD_W-1:0]  MAGIC_TRACK     = 32'h4D54_726B;
	localparam logic [FIELD_W-1:0]  HEAD_LENGTH     = 32'd6;
	localparam logic [DIV_W-1:0]    FORMAT_MAX      = 16'd2;
	localparam logic [DCOUNT_W-1:0] MAX_DELTA_BYTES = 4'd8;

	// Byte positions inside the chunk heads.
	localparam logic [POS_W-1:0] POS_MAGIC_LAST  = 5'd3;
	localparam logic [POS_W-1:0] POS_HLEN_LAST   = 5'd7;
	localparam logic [POS_W-1:0] POS_FORMAT_LAST = 5'd9;
	localparam logic [POS_W-1:0] POS_HEAD_LAST   = 5'd13;
	localparam logic [POS_W-1:0] POS_TLEN_LAST   = 5'd7;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_TRACK  = 3'd1,
		PH_DELTA  = 3'd2,
		PH_DONE   = 3'd3,
		PH_ERROR  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_TRACK  = 2'd1,
		KIND_DELTA  = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_MTHD      = 3'd1,
		ERR_HEAD_LEN  = 3'd2,
		ERR_FORMAT    = 3'd3,
		ERR_MTRK      = 3'd4,
		ERR_DELTA_LEN = 3'd5
	} err_t;

	typedef struct packed {
		kind_t               kind;
		logic [FMT_W-1:0]    file_format;
		logic [DIV_W-1:0]    time_division;
		logic [FIELD_W-1:0]  track_length;
		logic [DELTA_W-1:0]  delta_time;
		err_t                error_code;
	} result_t;

endpackage

/* hdl/mfhp_byte_if.sv */
// ----------------------------------------------------------------------------
// MIDI file byte channel
// Valid/ready channel that carries one file byte and the restart flag.
// ----------------------------------------------------------------------------
interface mfhp_byte_if import mfhp_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_in;
	logic              restart;

	modport source (output valid, output byte_in, output restart, input ready);
	modport sink (input valid, input byte_in, input restart, output ready);

endinterface

/* hdl/mfhp_result_if.sv */
// ----------------------------------------------------------------------------
// MIDI file result channel
// Valid/ready channel that carries one parse result.
// ----------------------------------------------------------------------------
interface mfhp_result_if import mfhp_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [FMT_W-1:0]   file_format;
	logic [DIV_W-1:0]   time_division;
	logic [FIELD_W-1:0] track_length;
	logic [DELTA_W-1:0] delta_time;
	logic [2:0]         error_code;

	modport source (
		output valid, output kind, output file_format, output time_division,
		output track_length, output delta_time, output error_code, input ready
	);
	modport sink (
		input valid, input kind, input file_format, input time_division,
		input track_length, input delta_time, input error_code, output ready
	);

endinterface

/* hdl/mfhp_core.sv */
// ----------------------------------------------------------------------------
// MIDI file parser core
// Parse state registers and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module mfhp_core import mfhp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [BYTE_W-1:0] byte_in,
	input  logic              restart,
	output logic              res_valid,
	output result_t           res
);

	phase_t                phase_q, phase_n, phase_e;
	logic [POS_W-1:0]      pos_q, pos_n, pos_e;
	logic [FIELD_W-1:0]    shift_q, shift_n, shift_e, shifted;
	logic [FMT_W-1:0]      fmt_q, fmt_n, fmt_e;
	logic [DELTA_W-1:0]    acc_q, acc_n, acc_e;
	logic [DCOUNT_W-1:0]   cnt_q, cnt_n, cnt_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			shift_q <= '0;
			fmt_q   <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			shift_q <= shift_n;
			fmt_q   <= fmt_n;
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
		end
	end

	always_comb begin
		// A restart byte is parsed as though the state had just been reset.
		phase_e = restart ? PH_HEADER : phase_q;
		pos_e   = restart ? '0 : pos_q;
		shift_e = restart ? '0 : shift_q;
		fmt_e   = restart ? '0 : fmt_q;
		acc_e   = restart ? '0 : acc_q;
		cnt_e   = restart ? '0 : cnt_q;
		shifted = {shift_e[FIELD_W-BYTE_W-1:0], byte_in};

		phase_n   = phase_e;
		pos_n     = pos_e;
		shift_n   = shift_e;
		fmt_n     = fmt_e;
		acc_n     = acc_e;
		cnt_n     = cnt_e;
		res_valid = 1'b0;
		res       = '0;

		case (phase_e)
			PH_HEADER: begin
				shift_n = shifted;
				pos_n   = pos_e + 5'd1;
				if (pos_e == POS_MAGIC_LAST && shifted != MAGIC_HEAD) begin
					phase_n        = PH_ERROR;
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_MTHD;
				end else if (pos_e == POS_HLEN_LAST && shifted != HEAD_LENGTH) begin
					phase_n        = PH_ERROR;
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_HEAD_LEN;
				end else if (pos_e == POS_FORMAT_LAST && shifted[DIV_W-1:0] > FORMAT_MAX) begin
					phase_n        = PH_ERROR;
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_FORMAT;
				end else begin
					if (pos_e == POS_FORMAT_LAST) begin
						fmt_n = shifted[FMT_W-1:0];
					end
					if (pos_e >= POS_HEAD_LAST) begin
						phase_n           = PH_TRACK;
						pos_n             = '0;
						res_valid         = 1'b1;
						res.kind          = KIND_HEADER;
						res.file_format   = fmt_e;
						res.time_division = shifted[DIV_W-1:0];
					end
				end
			end
			PH_TRACK: begin
				shift_n = shifted;
				pos_n   = pos_e + 5'd1;
				if (pos_e == POS_MAGIC_LAST && shifted != MAGIC_TRACK) begin
					phase_n        = PH_ERROR;
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_MTRK;
				end else if (pos_e >= POS_TLEN_LAST) begin
					phase_n          = PH_DELTA;
					pos_n            = '0;
					acc_n            = '0;
					cnt_n            = '0;
					res_valid        = 1'b1;
					res.kind         = KIND_TRACK;
					res.track_length = shifted;
				end
			end
			PH_DELTA: begin
				acc_n = {acc_e[DELTA_W-8:0], byte_in[BYTE_W-2:0]};
				cnt_n = cnt_e + 4'd1;
				if (!byte_in[BYTE_W-1]) begin
					phase_n        = PH_DONE;
					res_valid      = 1'b1;
					res.kind       = KIND_DELTA;
					res.delta_time = acc_n;
				end else if (cnt_n >= MAX_DELTA_BYTES) begin
					phase_n        = PH_ERROR;
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_DELTA_LEN;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* hdl/mfhp_out_reg.sv */
// ----------------------------------------------------------------------------
// MIDI file parser result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module mfhp_out_reg import mfhp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  logic    res_valid,
	input  result_t res,
	output logic    space,
	mfhp_result_if.source events
);

	logic    valid_q;
	result_t res_q;

	// A new byte may enter when the register is empty or drains this cycle.
	assign space = !valid_q || events.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res_valid;
		end else if (events.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res_valid) begin
			res_q <= res;
		end
	end

	assign events.valid         = valid_q;
	assign events.kind          = res_q.kind;
	assign events.file_format   = res_q.file_format;
	assign events.time_division = res_q.time_division;
	assign events.track_length  = res_q.track_length;
	assign events.delta_time    = res_q.delta_time;
	assign events.error_code    = res_q.error_code;

endmodule

/* hdl/midi_file_header_parser.sv */
// ----------------------------------------------------------------------------
// MIDI file header parser
// Checks the header and first track chunk head and decodes the first delta.
// ----------------------------------------------------------------------------
// Takes one file byte per transaction and can take one every cycle; a result,
// when a byte causes one, appears on the result channel on the next cycle from
// a single result register. The byte channel stalls only while that register
// holds a result that has not been taken. After a delta, or after an error,
// bytes are taken but give no result until a byte arrives with restart set.
module midi_file_header_parser import mfhp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	mfhp_byte_if.sink     stream,
	mfhp_result_if.source events
);

	logic    space;
	logic    take;
	logic    res_valid;
	result_t res;

	assign stream.ready = space;
	assign take         = stream.valid && space;

	mfhp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (take),
		.byte_in   (stream.byte_in),
		.restart   (stream.restart),
		.res_valid (res_valid),
		.res       (res)
	);

	mfhp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.res_valid (res_valid),
		.res       (res),
		.space     (space),
		.events    (events)
	);

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI file header parser testbench
// This bench feeds directed and random MIDI file heads into the parser, byte
// by byte. Both channels idle and stall at random. A cycle-free model of the
// parser predicts each result, and the bench checks every result field.
// ----------------------------------------------------------------------------
module testbench;
	import mfhp_pkg::*;

	typedef logic [BYTE_W-1:0] byte_q_t [$];

	typedef enum int {
		SC_GOOD,
		SC_BAD_MTHD,
		SC_BAD_HLEN,
		SC_BAD_FORMAT,
		SC_BAD_MTRK,
		SC_LONG_DELTA,
		SC_TRUNCATED,
		SC_NOISE,
		SC_COUNT
	} scenario_t;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_BYTES   = 1050;
	localparam int HEAD_BYTES     = 22;

	logic clk;
	logic arst_n;

	mfhp_byte_if   byte_ch();
	mfhp_result_if result_ch();

	midi_file_header_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (byte_ch),
		.events (result_ch)
	);

	// Parser model state.
	logic [POS_W-1:0]    parse_pos;
	phase_t              phase;
	logic [FIELD_W-1:0]  shift_reg;
	logic [FMT_W-1:0]    kept_format;
	logic [DELTA_W-1:0]  delta_acc;
	logic [DCOUNT_W-1:0] delta_cnt;

	result_t pending_results [$];
	int      fail_count;
	int      sent_count;
	int      idle_cycles;
	bit      no_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_parser();
		parse_pos   = '0;
		phase       = PH_HEADER;
		shift_reg   = '0;
		kept_format = '0;
		delta_acc   = '0;
		delta_cnt   = '0;
	endfunction

	function automatic bit flag_error(input err_t code, output result_t res);
		phase          = PH_ERROR;
		res            = '0;
		res.kind       = KIND_ERROR;
		res.error_code = code;
		return 1'b1;
	endfunction

	// Advances the model by one byte; returns 1 when the byte yields a result.
	function automatic bit parse_byte(input logic [BYTE_W-1:0] b, input logic rs,
			output result_t res);
		logic [POS_W-1:0] pos;
		res = '0;
		if (rs)
			clear_parser();
		if (phase == PH_HEADER || phase == PH_TRACK)
			shift_reg = {shift_reg[FIELD_W-BYTE_W-1:0], b};
		pos = parse_pos;
		case (phase)
			PH_HEADER: begin
				parse_pos = pos + 5'd1;
				if (pos == POS_MAGIC_LAST && shift_reg != MAGIC_HEAD)
					return flag_error(ERR_MTHD, res);
				if (pos == POS_HLEN_LAST && shift_reg != HEAD_LENGTH)
					return flag_error(ERR_HEAD_LEN, res);
				if (pos == POS_FORMAT_LAST) begin
					if (shift_reg[DIV_W-1:0] > FORMAT_MAX)
						return flag_error(ERR_FORMAT, res);
					kept_format = shift_reg[FMT_W-1:0];
				end
				if (pos >= POS_HEAD_LAST) begin
					phase             = PH_TRACK;
					parse_pos         = '0;
					res.kind          = KIND_HEADER;
					res.file_format   = kept_format;
					res.time_division = shift_reg[DIV_W-1:0];
					return 1'b1;
				end
			end
			PH_TRACK: begin
				parse_pos = pos + 5'd1;
				if (pos == POS_MAGIC_LAST && shift_reg != MAGIC_TRACK)
					return flag_error(ERR_MTRK, res);
				if (pos >= POS_TLEN_LAST) begin
					phase            = PH_DELTA;
					parse_pos        = '0;
					delta_acc        = '0;
					delta_cnt        = '0;
					res.kind         = KIND_TRACK;
					res.track_length = shift_reg;
					return 1'b1;
				end
			end
			PH_DELTA: begin
				delta_acc = {delta_acc[DELTA_W-8:0], b[6:0]};
				delta_cnt = delta_cnt + 4'd1;
				if (!b[7]) begin
					phase          = PH_DONE;
					res.kind       = KIND_DELTA;
					res.delta_time = delta_acc;
					return 1'b1;
				end
				if (delta_cnt >= MAX_DELTA_BYTES)
					return flag_error(ERR_DELTA_LEN, res);
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic int draw_wait();
		if (no_idle)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	// Variable-length quantity, most significant group first.
	function automatic byte_q_t encode_delta(input logic [DELTA_W-1:0] value,
			input int groups);
		byte_q_t q;
		logic [BYTE_W-1:0] grp;
		for (int g = groups - 1; g >= 0; g--) begin
			grp = {g != 0, value[g*7 +: 7]};
			q   = {q, grp};
		end
		return q;
	endfunction

	function automatic byte_q_t make_file(input logic [15:0] fmt, input logic [15:0] tracks,
			input logic [15:0] div, input logic [31:0] tlen, input byte_q_t delta);
		byte_q_t q;
		logic [HEAD_BYTES*8-1:0] head;
		head = {MAGIC_HEAD, HEAD_LENGTH, fmt, tracks, div, MAGIC_TRACK, tlen};
		for (int i = HEAD_BYTES - 1; i >= 0; i--)
			q = {q, head[i*8 +: 8]};
		foreach (delta[i])
			q = {q, delta[i]};
		return q;
	endfunction

	// Keeps valid high across back-to-back transactions.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic rs);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.byte_in <= b;
		byte_ch.restart <= rs;
		do @(posedge clk); while (!byte_ch.ready);
		sent_count++;
	endtask

	task automatic send_stream(input byte_q_t q);
		foreach (q[i])
			send_byte(q[i], i == 0);
	endtask

	task automatic test_extremes();
		// Largest format, division, track length and an eight-byte delta.
		send_stream(make_file(16'd2, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, encode_delta('1, 8)));
		// Once done, the parser stays silent.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// A bad magic fails on its fourth byte, then the parser is silent.
		send_byte(8'h4D, 1'b1);
		send_byte(8'h54, 1'b0);
		send_byte(8'h68, 1'b0);
		send_byte(8'h65, 1'b0);
		send_byte(8'h64, 1'b0);
	endtask

	task automatic test_random_files();
		int        start;
		int        idx;
		int        groups;
		int        k;
		int        n;
		scenario_t sc;
		byte_q_t   q;
		logic [15:0] fmt;
		logic [15:0] div;
		logic [31:0] tlen;
		logic [DELTA_W-1:0] value;
		start = sent_count;
		idx   = 0;
		while (sent_count < start + RANDOM_BYTES) begin
			// Every other file is well formed; the rest cycle through the failures.
			if (idx % 2 == 0)
				sc = SC_GOOD;
			else
				sc = scenario_t'(1 + (idx / 2) % (SC_COUNT - 1));
			idx++;
			no_idle = ($urandom_range(0, 4) == 0);

			fmt = 16'($urandom_range(0, 2));
			case ($urandom_range(0, 5))
				0:       div = '0;
				1:       div = '1;
				default: div = 16'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0:       tlen = '0;
				1:       tlen = '1;
				default: tlen = $urandom;
			endcase
			groups = $urandom_range(1, 8);
			case ($urandom_range(0, 5))
				0:       value = '0;
				1:       value = '1;
				default: value = DELTA_W'({$urandom, $urandom});
			endcase
			value = value & ((56'd1 << (groups * 7)) - 56'd1);
			q = make_file(fmt, 16'($urandom), div, tlen, encode_delta(value, groups));

			case (sc)
				SC_BAD_MTHD: begin
					k = $urandom_range(0, 3);
					q[k] = q[k] ^ (8'd1 << $urandom_range(0, 7));
				end
				SC_BAD_HLEN: begin
					k = $urandom_range(4, 7);
					q[k] = q[k] ^ (8'd1 << $urandom_range(0, 7));
				end
				SC_BAD_FORMAT: begin
					fmt  = 16'($urandom_range(3, 65535));
					q[8] = fmt[15:8];
					q[9] = fmt[7:0];
				end
				SC_BAD_MTRK: begin
					k = $urandom_range(14, 17);
					q[k] = q[k] ^ (8'd1 << $urandom_range(0, 7));
				end
				SC_LONG_DELTA: begin
					while (q.size() > HEAD_BYTES)
						q.delete(q.size() - 1);
					repeat (MAX_DELTA_BYTES)
						q = {q, 8'h80 | 8'($urandom)};
				end
				SC_TRUNCATED: begin
					// The next file restarts the parser in the middle of this one.
					n = $urandom_range(1, q.size() - 1);
					while (q.size() > n)
						q.delete(q.size() - 1);
				end
				SC_NOISE: begin
					q.delete();
					repeat ($urandom_range(1, 6))
						q = {q, 8'($urandom)};
				end
				default: ;
			endcase
			send_stream(q);

			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3))
					send_byte(8'($urandom), 1'b0);
			end
		end
	endtask

	// Result sink with random stalls.
	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	// Model update on each byte transaction, result check and watchdog.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				if (parse_byte(byte_ch.byte_in, byte_ch.restart, want))
					pending_results = {pending_results, want};
			end
			if (result_ch.valid && result_ch.ready) begin
				if (pending_results.size() == 0) begin
					$error("result with no expectation pending, kind %0d", result_ch.kind);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("kind", want.kind, result_ch.kind);
					check_field("file_format", want.file_format, result_ch.file_format);
					check_field("time_division", want.time_division, result_ch.time_division);
					check_field("track_length", want.track_length, result_ch.track_length);
					check_field("delta_time", want.delta_time, result_ch.delta_time);
					check_field("error_code", want.error_code, result_ch.error_code);
				end
			end
			if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		byte_ch.valid   <= 1'b0;
		byte_ch.byte_in <= '0;
		byte_ch.restart <= 1'b0;
		arst_n          <= 1'b0;
		fail_count  = 0;
		sent_count  = 0;
		idle_cycles = 0;
		no_idle     = 1'b0;
		clear_parser();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_random_files();

		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
